FILE: rtl/brsc_pkg.sv
package brsc_pkg;

    localparam int NUM_PROCESSES = 8;
    localparam int NUM_RESOURCES = 4;

    localparam int CMD_W    = 3;
    localparam int PROC_W   = 4;
    localparam int RES_W    = 3;
    localparam int AMT_W    = 8;
    localparam int STATUS_W = 3;
    localparam int WORK_W   = 13;

    localparam int PIDX_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int RIDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int CNT_W  = $clog2(NUM_PROCESSES + 1);

    localparam logic [CMD_W-1:0] CMD_WR_MAX   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_ALLOC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_AVAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STAGE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EVAL     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLAIM   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_AVAIL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNSAFE  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic check;
        logic scan;
        logic undo;
        logic report;
        logic emit;
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic check_fail;
        logic scan_done;
        logic scan_dead;
        logic emit_last;
    } t_dp_status;

endpackage

FILE: rtl/brsc_if.sv
interface brsc_req_if
    import brsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PROC_W-1:0] process;
    logic [RES_W-1:0]  resource;
    logic [AMT_W-1:0]  amount;

    modport source (output valid, command, process, resource, amount, input ready);
    modport sink   (input valid, command, process, resource, amount, output ready);
endinterface

interface brsc_rsp_if
    import brsc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PROC_W-1:0]   sequence_process;
    logic                last;

    modport source (output valid, status, sequence_process, last, input ready);
    modport sink   (input valid, status, sequence_process, last, output ready);
endinterface

FILE: rtl/brsc_datapath.sv
module brsc_datapath
    import brsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_ctrl            i_ctl,
    output t_dp_status          o_sts,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [PROC_W-1:0]   i_process,
    input  logic [RES_W-1:0]    i_resource,
    input  logic [AMT_W-1:0]    i_amount,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [PROC_W-1:0]   o_sequence_process,
    output logic                o_last
);

    function automatic logic [AMT_W-1:0] f_need(input logic [AMT_W-1:0] m,
                                                input logic [AMT_W-1:0] a);
        return (m > a) ? (m - a) : '0;
    endfunction

    logic [AMT_W-1:0]  r_max   [NUM_PROCESSES][NUM_RESOURCES];
    logic [AMT_W-1:0]  r_alloc [NUM_PROCESSES][NUM_RESOURCES];
    logic [AMT_W-1:0]  r_avail [NUM_RESOURCES];
    logic [AMT_W-1:0]  r_req   [NUM_RESOURCES];
    logic [WORK_W-1:0] r_work  [NUM_RESOURCES];
    logic [NUM_PROCESSES-1:0] r_finished;
    logic [PROC_W-1:0] r_seq   [NUM_PROCESSES];

    logic [PROC_W-1:0]   r_proc;
    logic [PIDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]    r_count;
    logic                r_progress;
    logic [PIDX_W-1:0]   r_emit_k;
    logic [STATUS_W-1:0] r_code;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [PROC_W-1:0]   r_out_seq;
    logic                r_out_last;

    logic [PIDX_W-1:0] w_pidx;
    logic [PIDX_W-1:0] w_in_pidx;
    logic [RIDX_W-1:0] w_in_ridx;
    logic              w_p_ok;
    logic              w_in_p_ok;
    logic              w_in_r_ok;
    logic              w_claim_fail;
    logic              w_avail_fail;
    logic              w_fits;
    logic              w_scan_end;
    logic [AMT_W-1:0]  w_avail_less [NUM_RESOURCES];

    assign w_pidx    = r_proc[PIDX_W-1:0];
    assign w_in_pidx = i_process[PIDX_W-1:0];
    assign w_in_ridx = i_resource[RIDX_W-1:0];
    assign w_p_ok    = {1'b0, r_proc} < (PROC_W+1)'(NUM_PROCESSES);
    assign w_in_p_ok = {1'b0, i_process} < (PROC_W+1)'(NUM_PROCESSES);
    assign w_in_r_ok = {1'b0, i_resource} < (RES_W+1)'(NUM_RESOURCES);

    always_comb begin
        w_claim_fail = !w_p_ok;
        w_avail_fail = 1'b0;
        w_fits       = !r_finished[r_idx];
        for (int j = 0; j < NUM_RESOURCES; j++) begin
            if (r_req[j] > f_need(r_max[w_pidx][j], r_alloc[w_pidx][j])) begin
                w_claim_fail = 1'b1;
            end
            if (r_req[j] > r_avail[j]) begin
                w_avail_fail = 1'b1;
            end
            if (WORK_W'(f_need(r_max[r_idx][j], r_alloc[r_idx][j])) > r_work[j]) begin
                w_fits = 1'b0;
            end
            w_avail_less[j] = r_avail[j] - r_req[j];
        end
    end

    assign w_scan_end = r_idx == PIDX_W'(NUM_PROCESSES - 1);

    assign o_sts.out_free   = !r_out_valid || i_ready;
    assign o_sts.check_fail = w_claim_fail || w_avail_fail;
    assign o_sts.scan_done  = w_fits && (r_count == CNT_W'(NUM_PROCESSES - 1));
    assign o_sts.scan_dead  = w_scan_end && !(r_progress || w_fits);
    assign o_sts.emit_last  = r_emit_k == PIDX_W'(NUM_PROCESSES - 1);

    // Tables: host writes, tentative apply and rollback of the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PROCESSES; p++) begin
                for (int j = 0; j < NUM_RESOURCES; j++) begin
                    r_max[p][j]   <= '0;
                    r_alloc[p][j] <= '0;
                end
            end
            for (int j = 0; j < NUM_RESOURCES; j++) begin
                r_avail[j] <= '0;
                r_req[j]   <= '0;
            end
        end else if (i_ctl.accept) begin
            unique case (i_command)
                CMD_WR_MAX: begin
                    if (w_in_p_ok && w_in_r_ok) r_max[w_in_pidx][w_in_ridx] <= i_amount;
                end
                CMD_WR_ALLOC: begin
                    if (w_in_p_ok && w_in_r_ok) r_alloc[w_in_pidx][w_in_ridx] <= i_amount;
                end
                CMD_WR_AVAIL: begin
                    if (w_in_r_ok) r_avail[w_in_ridx] <= i_amount;
                end
                CMD_STAGE: begin
                    if (w_in_r_ok) r_req[w_in_ridx] <= i_amount;
                end
                default: begin
                end
            endcase
        end else if (i_ctl.check && !o_sts.check_fail) begin
            for (int j = 0; j < NUM_RESOURCES; j++) begin
                r_avail[j]        <= w_avail_less[j];
                r_alloc[w_pidx][j] <= r_alloc[w_pidx][j] + r_req[j];
            end
        end else if (i_ctl.undo) begin
            for (int j = 0; j < NUM_RESOURCES; j++) begin
                r_avail[j]        <= r_avail[j] + r_req[j];
                r_alloc[w_pidx][j] <= r_alloc[w_pidx][j] - r_req[j];
            end
        end
    end

    // Safety scan: one process per cycle, passes repeat in index order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finished <= '0;
            r_idx      <= '0;
            r_count    <= '0;
            r_progress <= 1'b0;
            r_emit_k   <= '0;
            r_code     <= ST_DONE;
            r_proc     <= '0;
        end else begin
            if (i_ctl.accept) begin
                r_proc <= i_process;
            end
            if (i_ctl.check) begin
                r_code     <= w_claim_fail ? ST_CLAIM : ST_AVAIL;
                r_finished <= '0;
                r_idx      <= '0;
                r_count    <= '0;
                r_progress <= 1'b0;
                r_emit_k   <= '0;
                for (int j = 0; j < NUM_RESOURCES; j++) begin
                    r_work[j] <= WORK_W'(w_avail_less[j]);
                end
            end
            if (i_ctl.scan) begin
                if (w_fits) begin
                    for (int j = 0; j < NUM_RESOURCES; j++) begin
                        r_work[j] <= r_work[j] + WORK_W'(r_alloc[r_idx][j]);
                    end
                    r_seq[r_count[PIDX_W-1:0]] <= PROC_W'(r_idx);
                    r_count             <= r_count + 1'b1;
                    r_finished[r_idx]   <= 1'b1;
                end
                if (w_scan_end) begin
                    r_idx      <= '0;
                    r_progress <= 1'b0;
                end else begin
                    r_idx      <= r_idx + 1'b1;
                    r_progress <= r_progress || w_fits;
                end
            end
            if (i_ctl.undo) begin
                r_code <= ST_UNSAFE;
            end
            if (i_ctl.emit) begin
                r_emit_k <= r_emit_k + 1'b1;
            end
        end
    end

    // Output register; the controller loads it only while it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_ctl.accept && (i_command != CMD_EVAL)) || i_ctl.report
                     || i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && (i_command != CMD_EVAL)) begin
            r_out_status <= ST_DONE;
            r_out_seq    <= '0;
            r_out_last   <= 1'b1;
        end else if (i_ctl.report) begin
            r_out_status <= r_code;
            r_out_seq    <= '0;
            r_out_last   <= 1'b1;
        end else if (i_ctl.emit) begin
            r_out_status <= ST_GRANTED;
            r_out_seq    <= r_seq[r_emit_k];
            r_out_last   <= o_sts.emit_last;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_sequence_process = r_out_seq;
    assign o_last             = r_out_last;

endmodule

FILE: rtl/brsc_controller.sv
module brsc_controller
    import brsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_eval,
    output logic       o_req_ready,
    output t_dp_ctrl   o_ctl,
    input  t_dp_status i_sts
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_UNDO   = 6'b001000,
        S_REPORT = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.accept = o_req_ready && i_req_valid;
                if (o_ctl.accept && i_req_eval) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_ctl.check = 1'b1;
                n_state = i_sts.check_fail ? S_REPORT : S_SCAN;
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_EMIT;
                end else if (i_sts.scan_dead) begin
                    n_state = S_UNDO;
                end
            end
            S_UNDO: begin
                o_ctl.undo = 1'b1;
                n_state = S_REPORT;
            end
            S_REPORT: begin
                if (i_sts.out_free) begin
                    o_ctl.report = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    if (i_sts.emit_last) n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/bankers_request_and_safety_check.sv
// Banker's-algorithm request checker.
// i_req carries commands: writes of the max-claim table, the allocation table,
// the available vector and the staged request, and evaluate for one process.
// o_rsp returns results; the last result of each command has last set.
// A table write or staging command gives one result with status done in the
// cycle after acceptance, and such commands may follow one another every cycle
// while the receiver keeps ready high. Evaluate runs the claim and available
// checks in the check state; a rejection goes on through the report state to
// the output register. A passing request is applied and the safety scan tests
// one process per cycle against the work vector. A safe request then emits
// NUM_PROCESSES granted results, one per cycle while ready is high, in
// safe-sequence order; an unsafe one is rolled back in the undo state and
// reports status unsafe. No new command is taken until an evaluate is done.
// Reset clears all tables and drops o_rsp.valid. When the receiver holds
// ready low the result stays in the output register and the block waits.
module bankers_request_and_safety_check
    import brsc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    brsc_req_if.sink        i_req,
    brsc_rsp_if.source      o_rsp
);

    t_dp_ctrl   w_ctl;
    t_dp_status w_sts;
    logic       w_req_eval;

    assign w_req_eval = i_req.command == CMD_EVAL;

    brsc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_eval  (w_req_eval),
        .o_req_ready (i_req.ready),
        .o_ctl       (w_ctl),
        .i_sts       (w_sts)
    );

    brsc_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_ctl),
        .o_sts              (w_sts),
        .i_command          (i_req.command),
        .i_process          (i_req.process),
        .i_resource         (i_req.resource),
        .i_amount           (i_req.amount),
        .o_valid            (o_rsp.valid),
        .i_ready            (o_rsp.ready),
        .o_status           (o_rsp.status),
        .o_sequence_process (o_rsp.sequence_process),
        .o_last             (o_rsp.last)
    );

endmodule

FILE: rtl/brsc_checker.sv
module brsc_checker
    import brsc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic [CMD_W-1:0]    i_in_command,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_out_status,
    input logic [PROC_W-1:0]   i_out_seq,
    input logic                i_out_last
);

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_seq) && $stable(i_out_last))
        else $error("stalled result changed");

    // Anything but evaluate answers with one done result in the next cycle.
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command != CMD_EVAL)
            |=> i_out_valid && (i_out_status == ST_DONE) && i_out_last)
        else $error("write transaction without a done result");

    // The granted sequence streams without gaps once a result is taken.
    a_seq_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_status == ST_GRANTED) && !i_out_last
            |=> i_out_valid && (i_out_status == ST_GRANTED))
        else $error("gap in granted sequence");

    // No command is taken while a granted sequence is still being sent.
    a_no_accept_mid_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_GRANTED) && !i_out_last |-> !i_in_ready)
        else $error("input accepted during granted sequence");

    // Only granted results carry a process index.
    a_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_GRANTED) |-> i_out_seq == '0)
        else $error("process index on a non-granted result");

endmodule

bind bankers_request_and_safety_check brsc_checker u_brsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_in_command (i_req.command),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.status),
    .i_out_seq    (o_rsp.sequence_process),
    .i_out_last   (o_rsp.last)
);
